FILE: rtl/fm_voice_allocator_core_assert.svh
// Assertion macros for the voice allocator checker.
`ifndef FM_VOICE_ALLOCATOR_CORE_ASSERT_SVH
`define FM_VOICE_ALLOCATOR_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define FVA_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define FVA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/fm_va_pkg.sv
// Types, constants and voice-class helpers for the FM voice allocator.
package fm_va_pkg;

	localparam int NUM_VOICES_DEF = 18;
	localparam int AGE_WIDTH_DEF  = 32;

	localparam int CNT_W   = 5;
	localparam int CHAN_W  = 4;
	localparam int NOTE_W  = 7;
	localparam int VOICE_W = 5;

	// a four-op head is paired with the voice this far above it
	localparam int PAIR_OFF = 3;

	localparam logic OP_NOTE_ON  = 1'b0;
	localparam logic OP_NOTE_OFF = 1'b1;

	typedef enum logic [1:0] {
		MODE_OFF = 2'd0,
		MODE_ON2 = 2'd1,
		MODE_ON4 = 2'd2,
		MODE_NA  = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_UPDATE,
		ST_OFF_SCAN,
		ST_FINISH
	} state_t;

	// per-voice bookkeeping other than the age
	typedef struct packed {
		mode_t             mode;
		logic [NOTE_W-1:0] note;
		logic [CHAN_W-1:0] owner;
	} vmeta_t;

	// heads of four-op pairs: 0-2 and 9-11
	function automatic logic is_head(logic [CNT_W-1:0] i);
		return (i < 5'd3) || (i > 5'd8 && i < 5'd12);
	endfunction

	// voices that take part in a pair: 0-5 and 9-14
	function automatic logic is_bound(logic [CNT_W-1:0] i);
		return (i < 5'd6) || (i > 5'd8 && i < 5'd15);
	endfunction

endpackage

FILE: rtl/fm_va_cell.sv
// One voice slot of the rotating voice ring.
module fm_va_cell #(
	parameter int AGE_WIDTH = fm_va_pkg::AGE_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  shift,
	input  fm_va_pkg::vmeta_t     in_meta,
	input  logic [AGE_WIDTH-1:0]  in_age,
	output fm_va_pkg::vmeta_t     meta,
	output logic [AGE_WIDTH-1:0]  age
);

	fm_va_pkg::vmeta_t     meta_q;
	logic [AGE_WIDTH-1:0]  age_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meta_q <= '{mode: fm_va_pkg::MODE_OFF, note: '0, owner: '0};
			age_q  <= '0;
		end else if (shift) begin
			meta_q <= in_meta;
			age_q  <= in_age;
		end
	end

	assign meta = meta_q;
	assign age  = age_q;

endmodule

FILE: rtl/fm_va_ctrl.sv
// Sequencer: LRU search, allocate/release updates, use counter, result register.
module fm_va_ctrl #(
	parameter int NUM_VOICES = fm_va_pkg::NUM_VOICES_DEF,
	parameter int AGE_WIDTH  = fm_va_pkg::AGE_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              in_op,
	input  logic                              in_four,
	input  logic [fm_va_pkg::CHAN_W-1:0]      in_chan,
	input  logic [fm_va_pkg::NOTE_W-1:0]      in_note,
	input  logic [fm_va_pkg::CNT_W-1:0]       voice_count,
	input  fm_va_pkg::vmeta_t                 cur0,
	input  logic [AGE_WIDTH-1:0]              cur0_age,
	input  fm_va_pkg::vmeta_t                 cur3,
	input  logic [AGE_WIDTH-1:0]              cur3_age,
	output logic                              shift,
	output fm_va_pkg::vmeta_t                 nxt0,
	output logic [AGE_WIDTH-1:0]              nxt0_age,
	output fm_va_pkg::vmeta_t                 nxt3,
	output logic [AGE_WIDTH-1:0]              nxt3_age,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [fm_va_pkg::VOICE_W-1:0]     out_voice,
	output logic                              out_found,
	output logic                              out_released,
	output logic                              out_last
);

	localparam int VW = $clog2(NUM_VOICES);
	localparam logic [VW-1:0] LAST_IDX = VW'(NUM_VOICES - 1);
	localparam logic [fm_va_pkg::CNT_W-1:0] MAX_CNT = fm_va_pkg::CNT_W'(NUM_VOICES);

	fm_va_pkg::state_t state_q, state_d;

	logic                          op_q;
	logic                          four_q;
	logic [fm_va_pkg::CHAN_W-1:0]  chan_q;
	logic [fm_va_pkg::NOTE_W-1:0]  note_q;
	logic [VW-1:0]                 idx_q;
	logic [AGE_WIDTH-1:0]          ctr_q, ctr_d;

	logic [2:0]                    have_q;
	logic [AGE_WIDTH-1:0]          best_age_q [3];
	logic [VW-1:0]                 best_v_q [3];

	logic                          pend_valid_q;
	logic [VW-1:0]                 pend_voice_q;
	logic                          pend_found_q;

	logic                          out_valid_q;
	logic [fm_va_pkg::VOICE_W-1:0] out_voice_q;
	logic                          out_found_q;
	logic                          out_rel_q;
	logic                          out_last_q;

	logic [fm_va_pkg::CNT_W-1:0]   n_act;
	logic [fm_va_pkg::CNT_W-1:0]   idx5;
	logic                          in_range;
	logic                          pair_ok;
	logic                          step_last;
	logic                          out_free;
	logic                          accept;

	logic                          cand_ok;
	logic [1:0]                    cls;
	logic [AGE_WIDTH-1:0]          cand_age;
	logic                          better;
	logic                          have_any;
	logic [VW-1:0]                 pick;
	logic                          upd_hit;
	logic                          off_match;
	logic                          off_stall;
	logic                          off_hit;
	logic                          out_load;
	logic [fm_va_pkg::VOICE_W-1:0] out_voice_d;
	logic                          out_found_d;
	logic                          out_last_d;

	assign accept    = in_valid && in_ready;
	assign n_act     = (voice_count > MAX_CNT) ? MAX_CNT : voice_count;
	assign idx5      = fm_va_pkg::CNT_W'(idx_q);
	assign in_range  = idx5 < n_act;
	assign pair_ok   = ({1'b0, idx5} + 6'(fm_va_pkg::PAIR_OFF)) < 6'(NUM_VOICES);
	assign step_last = (idx_q == LAST_IDX);
	assign out_free  = !out_valid_q || out_ready;

	// cost class and effective age of the voice at the ring head
	always_comb begin
		cand_ok  = 1'b0;
		cls      = 2'd0;
		cand_age = cur0_age;
		if (in_range && cur0.mode != fm_va_pkg::MODE_NA) begin
			if (four_q) begin
				cand_ok = fm_va_pkg::is_head(idx5) && pair_ok;
				cls = 2'((cur0.mode != fm_va_pkg::MODE_OFF))
					+ 2'((cur3.mode == fm_va_pkg::MODE_ON2));
				if (cur3.mode == fm_va_pkg::MODE_ON2 && cur3_age > cur0_age) begin
					cand_age = cur3_age;
				end
			end else begin
				cand_ok = 1'b1;
				cls = 2'((fm_va_pkg::is_bound(idx5) || cur0.mode != fm_va_pkg::MODE_OFF))
					+ 2'((cur0.mode != fm_va_pkg::MODE_OFF));
			end
		end
		better = !have_q[cls] || (cand_age < best_age_q[cls]);
	end

	assign have_any = |have_q;

	always_comb begin
		priority if (have_q[0]) begin
			pick = best_v_q[0];
		end else if (have_q[1]) begin
			pick = best_v_q[1];
		end else if (have_q[2]) begin
			pick = best_v_q[2];
		end else begin
			pick = '0;
		end
	end

	assign upd_hit   = (state_q == fm_va_pkg::ST_UPDATE) && have_any && (idx_q == pick);
	assign off_match = in_range
		&& (cur0.mode == fm_va_pkg::MODE_ON2 || cur0.mode == fm_va_pkg::MODE_ON4)
		&& cur0.owner == chan_q && cur0.note == note_q;
	// an earlier match is still pending and the result register is full
	assign off_stall = (state_q == fm_va_pkg::ST_OFF_SCAN) && off_match
		&& pend_valid_q && !out_free;
	assign off_hit   = (state_q == fm_va_pkg::ST_OFF_SCAN) && off_match && !off_stall;

	// new contents for the head slot and its partner slot
	always_comb begin
		nxt0     = cur0;
		nxt0_age = cur0_age;
		nxt3     = cur3;
		nxt3_age = cur3_age;
		ctr_d    = ctr_q;
		if (upd_hit) begin
			nxt0_age   = ctr_q;
			nxt0.note  = note_q;
			nxt0.owner = chan_q;
			ctr_d      = ctr_q + AGE_WIDTH'(1);
			if (four_q) begin
				nxt0.mode  = fm_va_pkg::MODE_ON4;
				nxt3_age   = ctr_q + AGE_WIDTH'(1);
				nxt3.note  = note_q;
				nxt3.owner = chan_q;
				nxt3.mode  = fm_va_pkg::MODE_NA;
				ctr_d      = ctr_q + AGE_WIDTH'(2);
			end else begin
				nxt0.mode = fm_va_pkg::MODE_ON2;
				if (cur0.mode == fm_va_pkg::MODE_ON4 && pair_ok) begin
					nxt3_age  = ctr_q + AGE_WIDTH'(1);
					nxt3.mode = fm_va_pkg::MODE_OFF;
					ctr_d     = ctr_q + AGE_WIDTH'(2);
				end
			end
		end else if (off_hit) begin
			nxt0_age  = ctr_q;
			nxt0.mode = fm_va_pkg::MODE_OFF;
			ctr_d     = ctr_q + AGE_WIDTH'(1);
			if (cur0.mode == fm_va_pkg::MODE_ON4 && pair_ok) begin
				nxt3_age  = ctr_q + AGE_WIDTH'(1);
				nxt3.mode = fm_va_pkg::MODE_OFF;
				ctr_d     = ctr_q + AGE_WIDTH'(2);
			end
		end
	end

	// next state and result-register load
	always_comb begin
		state_d     = state_q;
		shift       = 1'b0;
		out_load    = 1'b0;
		out_voice_d = fm_va_pkg::VOICE_W'(pend_voice_q);
		out_found_d = 1'b1;
		out_last_d  = 1'b0;
		unique case (state_q)
			fm_va_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = (in_op == fm_va_pkg::OP_NOTE_OFF)
						? fm_va_pkg::ST_OFF_SCAN : fm_va_pkg::ST_SEARCH;
				end
			end
			fm_va_pkg::ST_SEARCH: begin
				shift = 1'b1;
				if (step_last) begin
					state_d = fm_va_pkg::ST_UPDATE;
				end
			end
			fm_va_pkg::ST_UPDATE: begin
				shift = 1'b1;
				if (step_last) begin
					state_d = fm_va_pkg::ST_FINISH;
				end
			end
			fm_va_pkg::ST_OFF_SCAN: begin
				shift = !off_stall;
				// a new match pushes the previous one out, not last
				out_load = off_hit && pend_valid_q;
				if (!off_stall && step_last) begin
					state_d = fm_va_pkg::ST_FINISH;
				end
			end
			fm_va_pkg::ST_FINISH: begin
				out_load    = out_free;
				out_voice_d = pend_valid_q ? fm_va_pkg::VOICE_W'(pend_voice_q) : '0;
				out_found_d = pend_valid_q && pend_found_q;
				out_last_d  = 1'b1;
				if (out_free) begin
					state_d = fm_va_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = fm_va_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fm_va_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q        <= '0;
			ctr_q        <= '0;
			have_q       <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			ctr_q <= ctr_d;
			if (accept) begin
				idx_q        <= '0;
				have_q       <= '0;
				pend_valid_q <= 1'b0;
			end else if (shift) begin
				idx_q <= step_last ? '0 : idx_q + VW'(1);
			end
			if (state_q == fm_va_pkg::ST_SEARCH && cand_ok && better) begin
				have_q[cls] <= 1'b1;
			end
			if (state_q == fm_va_pkg::ST_UPDATE && step_last) begin
				pend_valid_q <= 1'b1;
			end
			if (off_hit) begin
				pend_valid_q <= 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= in_op;
			four_q <= in_four;
			chan_q <= in_chan;
			note_q <= in_note;
		end
		if (state_q == fm_va_pkg::ST_SEARCH && cand_ok && better) begin
			best_age_q[cls] <= cand_age;
			best_v_q[cls]   <= idx_q;
		end
		if (state_q == fm_va_pkg::ST_UPDATE && step_last) begin
			pend_voice_q <= pick;
			pend_found_q <= have_any;
		end
		if (off_hit) begin
			pend_voice_q <= idx_q;
			pend_found_q <= 1'b1;
		end
		if (out_load) begin
			out_voice_q <= out_voice_d;
			out_found_q <= out_found_d;
			out_rel_q   <= op_q;
			out_last_q  <= out_last_d;
		end
	end

	assign in_ready     = (state_q == fm_va_pkg::ST_IDLE);
	assign out_valid    = out_valid_q;
	assign out_voice    = out_voice_q;
	assign out_found    = out_found_q;
	assign out_released = out_rel_q;
	assign out_last     = out_last_q;

endmodule

FILE: rtl/fm_voice_allocator_core.sv
// FM voice allocator top level: voice ring, sequencer and stream ports.
// Sequence: a note-on runs a search pass and then an update pass around the ring,
//   then FINISH loads the result; a note-off runs one scan pass, then FINISH.
// Throughput: one event at a time; FINISH waits for a free result register, and the
//   ring turns one voice per cycle except while a note-off match stalls on it.
// Reset (arst_n low): voices off, ages/notes/owners and use counter zero, count NUM_VOICES.
module fm_voice_allocator_core #(
	parameter int NUM_VOICES = fm_va_pkg::NUM_VOICES_DEF,
	parameter int AGE_WIDTH  = fm_va_pkg::AGE_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// voice count register
	input  logic        cfg_we,
	input  logic [4:0]  cfg_wdata,
	// event input
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [3:0] channel, [10:4] note_number, [15:11] zero
	input  logic [1:0]  s_axis_tuser,   // [0] operation, [1] four_op
	// result output
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // [4:0] voice, [5] found, [7:6] zero
	output logic        m_axis_tuser,   // [0] released
	output logic        m_axis_tlast
);

	// Ring position 0 is the working slot; position 3 holds its pair partner.
	// Every shift moves slot j+1 into slot j, and the working slot (after any
	// update) wraps into the top slot, so the ring is back in voice order
	// after NUM_VOICES shifts.
	localparam int PIDX = fm_va_pkg::PAIR_OFF;

	logic [fm_va_pkg::CNT_W-1:0]   count_q;

	fm_va_pkg::vmeta_t             cell_meta [NUM_VOICES];
	logic [AGE_WIDTH-1:0]          cell_age  [NUM_VOICES];
	fm_va_pkg::vmeta_t             cell_in_meta [NUM_VOICES];
	logic [AGE_WIDTH-1:0]          cell_in_age  [NUM_VOICES];

	logic                          shift;
	fm_va_pkg::vmeta_t             nxt0, nxt3;
	logic [AGE_WIDTH-1:0]          nxt0_age, nxt3_age;

	logic [fm_va_pkg::VOICE_W-1:0] out_voice;
	logic                          out_found;
	logic                          out_released;
	logic                          out_last;

	// config register; the user must write it only between events, the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= fm_va_pkg::CNT_W'(NUM_VOICES);
		end else if (cfg_we) begin
			count_q <= cfg_wdata;
		end
	end

	// ring wiring: the updated working slot re-enters at the top,
	// the updated partner drops into the slot below it
	for (genvar j = 0; j < NUM_VOICES; j++) begin : g_ring
		if (j == NUM_VOICES - 1) begin : g_top
			assign cell_in_meta[j] = nxt0;
			assign cell_in_age[j]  = nxt0_age;
		end else if (j == PIDX - 1) begin : g_partner
			assign cell_in_meta[j] = nxt3;
			assign cell_in_age[j]  = nxt3_age;
		end else begin : g_pass
			assign cell_in_meta[j] = cell_meta[j+1];
			assign cell_in_age[j]  = cell_age[j+1];
		end

		fm_va_cell #(
			.AGE_WIDTH (AGE_WIDTH)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.shift   (shift),
			.in_meta (cell_in_meta[j]),
			.in_age  (cell_in_age[j]),
			.meta    (cell_meta[j]),
			.age     (cell_age[j])
		);
	end

	fm_va_ctrl #(
		.NUM_VOICES (NUM_VOICES),
		.AGE_WIDTH  (AGE_WIDTH)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_axis_tvalid),
		.in_ready     (s_axis_tready),
		.in_op        (s_axis_tuser[0]),
		.in_four      (s_axis_tuser[1]),
		.in_chan      (s_axis_tdata[3:0]),
		.in_note      (s_axis_tdata[10:4]),
		.voice_count  (count_q),
		.cur0         (cell_meta[0]),
		.cur0_age     (cell_age[0]),
		.cur3         (cell_meta[PIDX]),
		.cur3_age     (cell_age[PIDX]),
		.shift        (shift),
		.nxt0         (nxt0),
		.nxt0_age     (nxt0_age),
		.nxt3         (nxt3),
		.nxt3_age     (nxt3_age),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.out_voice    (out_voice),
		.out_found    (out_found),
		.out_released (out_released),
		.out_last     (out_last)
	);

	// result beat packing
	assign m_axis_tdata = {2'b00, out_found, out_voice};
	assign m_axis_tuser = out_released;
	assign m_axis_tlast = out_last;

endmodule

FILE: rtl/fm_va_checker.sv
// Port-level checker for the FM voice allocator, bound to the top level.
`include "fm_voice_allocator_core_assert.svh"

module fm_va_checker #(
	parameter int NUM_VOICES = fm_va_pkg::NUM_VOICES_DEF
) (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [7:0]  m_axis_tdata,
	input logic        m_axis_tuser,
	input logic        m_axis_tlast
);

	// stalled result beat holds
	`FVA_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "result beat changed under stall")

	// one event at a time: no back-to-back input beats
	`FVA_ASSERT_NEXT(a_one_event, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input taken while busy")

	// a miss is always the only, hence last, result of its event
	`FVA_ASSERT_SAME(a_miss_last, m_axis_tvalid && !m_axis_tdata[5], m_axis_tlast, "miss result not last")

	// a miss reports voice zero
	`FVA_ASSERT_SAME(a_miss_zero, m_axis_tvalid && !m_axis_tdata[5], m_axis_tdata[4:0] == 5'd0, "miss result with nonzero voice")

	// reported voice lies inside the ring
	`FVA_ASSERT_SAME(a_voice_rng, m_axis_tvalid, m_axis_tdata[4:0] < 5'(NUM_VOICES), "voice index out of range")

endmodule

bind fm_voice_allocator_core fm_va_checker #(
	.NUM_VOICES (NUM_VOICES)
) u_fm_va_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);
